// File: design/bmia_pkg.sv
package bmia_pkg;

    // Default geometry of the usage bitmap
    localparam int ID_COUNT_DEF  = 1024;
    localparam int WORD_BITS_DEF = 32;

    // Field widths
    localparam int FID_W    = 11;
    localparam int GRANT_W  = 10;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd2;

endpackage

// File: design/bmia_ram.sv
module bmia_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/bmia_find0.sv
module bmia_find0 #(
    parameter int WIDTH = 32,
    parameter int IW    = 5
) (
    input  logic [WIDTH-1:0] i_word,
    output logic             o_found,
    output logic [IW-1:0]    o_index
);

    // Lowest clear bit wins: walk from the top so lower hits overwrite
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                o_found = 1'b1;
                o_index = IW'(i);
            end
        end
    end

endmodule

// File: design/bitmap_id_allocator_core.sv
// First-free identifier allocator. ID_COUNT identifiers are tracked as a
// usage bitmap of ceil(ID_COUNT / WORD_BITS) words held in a single-port-read,
// single-port-write RAM. After reset the block sweeps the RAM to zero, one word
// per cycle, and accepts no item during that sweep (32 words at the default
// geometry). An item on the slave side carries the request kind in tuser
// (0 allocate, 1 free) and the identifier to free in tdata. Each item yields
// exactly one result: granted identifier in tdata, status in tuser (0 ok,
// 1 no free identifier, 2 invalid identifier). One item is in work at a time.
// An allocate reads the bitmap one word per cycle from word 0 until it finds
// a word with a clear bit or has read the last word; a free reads the word
// that holds the identifier and writes it back with that bit cleared, and a
// free of an invalid identifier goes straight to the result. The result
// register lets the next item enter while a result still waits downstream.
module bitmap_id_allocator_core #(
    parameter int ID_COUNT  = bmia_pkg::ID_COUNT_DEF,
    parameter int WORD_BITS = bmia_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis_tdata: [10:0] free_id, [15:11] zero
    input  logic [bmia_pkg::S_DATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: [0] action
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // m_axis_tdata: [9:0] granted_id, [15:10] zero
    output logic [bmia_pkg::M_DATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: [1:0] status
    output logic [bmia_pkg::STATUS_W-1:0] m_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    localparam int FID_W      = bmia_pkg::FID_W;
    localparam int GRANT_W    = bmia_pkg::GRANT_W;
    localparam int STATUS_W   = bmia_pkg::STATUS_W;
    localparam int WORD_TOTAL = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_TOTAL - 1);

    // Bits of the last word at or above ID_COUNT read as used
    localparam int VALID_LAST = ID_COUNT - (WORD_TOTAL - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] PAD_MASK = {WORD_BITS{1'b1}} << VALID_LAST;

    // Identifier range check and id arithmetic widths
    localparam int ID_W   = $clog2(ID_COUNT) + 1;
    localparam int CMP_W  = (ID_W > FID_W) ? ID_W : FID_W;
    localparam int SUM_W  = (ID_W > GRANT_W) ? ID_W : GRANT_W;

    // Word index of a free request: exact reciprocal multiply for FID_W-bit ids
    localparam int DIV_SH  = FID_W + BIT_W;
    localparam int MUL_W   = FID_W + 2;
    localparam int PROD_W  = FID_W + MUL_W;
    localparam longint DIV_MUL = ((longint'(1) << DIV_SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [WADDR_W-1:0]  r_addr, n_addr;
    logic [FID_W-1:0]    r_fid, n_fid;
    logic [FID_W-1:0]    r_quot, n_quot;
    logic [GRANT_W-1:0]  r_res_gid, n_res_gid;
    logic [STATUS_W-1:0] r_res_st, n_res_st;
    logic                r_out_valid, n_out_valid;
    logic [GRANT_W-1:0]  r_out_gid, n_out_gid;
    logic [STATUS_W-1:0] r_out_st, n_out_st;

    logic                 w_rd_en;
    logic [WADDR_W-1:0]   w_rd_addr;
    logic [WORD_BITS-1:0] w_rd_data;
    logic                 w_wr_en;
    logic [WORD_BITS-1:0] w_wr_data;

    logic [FID_W-1:0]     w_in_fid;
    logic                 w_in_acc;
    logic                 w_fid_ok;
    logic [PROD_W-1:0]    w_prod;
    logic [PROD_W-1:0]    w_quot_full;
    logic [FID_W-1:0]     w_qd;
    logic [FID_W-1:0]     w_rem;
    logic [WORD_BITS-1:0] w_free_bit;
    logic [WORD_BITS-1:0] w_scan_word;
    logic                 w_found;
    logic [BIT_W-1:0]     w_found_idx;
    logic [SUM_W-1:0]     w_id;
    logic                 w_slot;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_fid      = s_axis_tdata[FID_W-1:0];
    assign w_fid_ok      = CMP_W'(w_in_fid) < CMP_W'(ID_COUNT);

    assign w_prod      = PROD_W'(w_in_fid) * PROD_W'(DIV_MUL);
    assign w_quot_full = w_prod >> DIV_SH;

    assign w_qd       = r_quot * FID_W'(WORD_BITS);
    assign w_rem      = r_fid - w_qd;
    assign w_free_bit = WORD_BITS'(1) << w_rem[BIT_W-1:0];

    assign w_scan_word = w_rd_data | ((r_addr == LAST_WORD) ? PAD_MASK : '0);
    assign w_id        = SUM_W'(r_addr) * SUM_W'(WORD_BITS) + SUM_W'(w_found_idx);

    assign w_slot = !r_out_valid || m_axis_tready;

    bmia_find0 #(
        .WIDTH (WORD_BITS),
        .IW    (BIT_W)
    ) u_find0 (
        .i_word  (w_scan_word),
        .o_found (w_found),
        .o_index (w_found_idx)
    );

    bmia_ram #(
        .DEPTH (WORD_TOTAL),
        .WIDTH (WORD_BITS),
        .AW    (WADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data)
    );

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fid       = r_fid;
        n_quot      = r_quot;
        n_res_gid   = r_res_gid;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_gid   = r_out_gid;
        n_out_st    = r_out_st;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr;
        w_wr_en     = 1'b0;
        w_wr_data   = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
                if (r_addr == LAST_WORD) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == bmia_pkg::ACT_ALLOC) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_addr    = '0;
                        n_state   = S_SCAN;
                    end else if (w_fid_ok) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = WADDR_W'(w_quot_full);
                        n_addr    = WADDR_W'(w_quot_full);
                        n_fid     = w_in_fid;
                        n_quot    = w_quot_full[FID_W-1:0];
                        n_state   = S_FREE;
                    end else begin
                        n_res_gid = '0;
                        n_res_st  = bmia_pkg::STAT_BAD_ID;
                        n_state   = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    w_wr_en   = 1'b1;
                    w_wr_data = w_rd_data | (WORD_BITS'(1) << w_found_idx);
                    n_res_gid = w_id[GRANT_W-1:0];
                    n_res_st  = bmia_pkg::STAT_OK;
                    n_state   = S_RESP;
                end else if (r_addr == LAST_WORD) begin
                    n_res_gid = '0;
                    n_res_st  = bmia_pkg::STAT_FULL;
                    n_state   = S_RESP;
                end else begin
                    // skip the full word, fetch the next
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr + 1'b1;
                    n_addr    = r_addr + 1'b1;
                end
            end
            S_FREE: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_rd_data & ~w_free_bit;
                n_res_gid = '0;
                n_res_st  = bmia_pkg::STAT_OK;
                n_state   = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_gid   = r_res_gid;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fid     <= n_fid;
        r_quot    <= n_quot;
        r_res_gid <= n_res_gid;
        r_res_st  <= n_res_st;
        r_out_gid <= n_out_gid;
        r_out_st  <= n_out_st;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = bmia_pkg::M_DATA_W'(r_out_gid);
    assign m_axis_tuser  = r_out_st;

endmodule

// File: tb/bitmap_id_allocator_core_tb.sv
module bitmap_id_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_COUNT    = bmia_pkg::ID_COUNT_DEF;
    localparam int FID_W       = bmia_pkg::FID_W;
    localparam int GRANT_W     = bmia_pkg::GRANT_W;
    localparam int STATUS_W    = bmia_pkg::STATUS_W;
    localparam int S_DATA_W    = bmia_pkg::S_DATA_W;
    localparam int M_DATA_W    = bmia_pkg::M_DATA_W;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_TAIL  = 40;

    typedef struct packed {
        logic [GRANT_W-1:0]  grant;
        logic [STATUS_W-1:0] status;
    } t_id_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // [10:0] free_id, [15:11] zero
    logic                s_axis_tuser = bmia_pkg::ACT_ALLOC;   // [0] action
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;   // [9:0] granted_id, [15:10] zero
    logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;

    // Predicted state: one bit per identifier, set when in use
    logic [ID_COUNT-1:0] used_ids = '0;
    t_id_result          owed_results[$];
    int                  mismatch_count = 0;
    int                  stall_cycles = 0;
    bit                  gaps_on = 1'b1;
    bit                  hold_request = 1'b0;

    bitmap_id_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Allocate takes the lowest clear identifier; free clears one bit
    function automatic t_id_result serve_request(input logic act,
                                                 input logic [FID_W-1:0] fid);
        t_id_result res;
        int         id;
        res.grant  = '0;
        res.status = bmia_pkg::STAT_OK;
        if (act == bmia_pkg::ACT_ALLOC) begin
            res.status = bmia_pkg::STAT_FULL;
            for (id = 0; id < ID_COUNT; id++) begin
                if (!used_ids[id]) begin
                    used_ids[id] = 1'b1;
                    res.grant    = id[GRANT_W-1:0];
                    res.status   = bmia_pkg::STAT_OK;
                    break;
                end
            end
        end else if (fid < ID_COUNT) begin
            used_ids[fid] = 1'b0;
        end else begin
            res.status = bmia_pkg::STAT_BAD_ID;
        end
        return res;
    endfunction

    function automatic int ids_in_use();
        return $countones(used_ids);
    endfunction

    // Mostly identifiers in use, some free ones, some out of range
    function automatic logic [FID_W-1:0] pick_free_target();
        logic [FID_W-1:0] cand;
        int               tries;
        case ($urandom_range(0, 7))
            0: return FID_W'($urandom_range(0, 2047));
            1: return FID_W'($urandom_range(ID_COUNT, 2047));
            default: begin
                cand = '0;
                for (tries = 0; tries < 16; tries++) begin
                    cand = FID_W'($urandom_range(0, ID_COUNT - 1));
                    if (used_ids[cand]) return cand;
                end
                return cand;
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Predict on accepted requests, compare accepted results in order
    always @(posedge i_clk) begin : result_check
        t_id_result got;
        t_id_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                owed_results.push_back(serve_request(s_axis_tuser,
                                                     s_axis_tdata[FID_W-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                got.grant  = m_axis_tdata[GRANT_W-1:0];
                got.status = m_axis_tuser;
                if (owed_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected item grant=%0d status=%0d",
                                            got.grant, got.status));
                end else begin
                    want = owed_results.pop_front();
                    if (got.grant !== want.grant)
                        note_mismatch($sformatf("grant expected %0d actual %0d",
                                                want.grant, got.grant));
                    if (got.status !== want.status)
                        note_mismatch($sformatf("status expected %0d actual %0d",
                                                want.status, got.status));
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random short stalls, or one long hold-off on request
    initial begin : result_sink
        int span;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                for (span = 0; span < HOLD_CYCLES; span++) @(posedge i_clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic act, input logic [FID_W-1:0] fid);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(S_DATA_W - FID_W){1'b0}}, fid};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    task automatic send_mixed(input int count, input int free_pct);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < free_pct)
                send_request(bmia_pkg::ACT_FREE, pick_free_target());
            else
                send_request(bmia_pkg::ACT_ALLOC, FID_W'($urandom_range(0, 2047)));
        end
    endtask

    task automatic test_directed();
        repeat (3) send_request(bmia_pkg::ACT_ALLOC, '0);
        send_request(bmia_pkg::ACT_FREE, 11'd1);
        send_request(bmia_pkg::ACT_ALLOC, '0);
        send_request(bmia_pkg::ACT_FREE, 11'd1);
        send_request(bmia_pkg::ACT_FREE, 11'd1);            // already free
        send_request(bmia_pkg::ACT_ALLOC, 11'h7FF);         // free_id ignored on allocate
        send_request(bmia_pkg::ACT_FREE, FID_W'(ID_COUNT - 1));
        send_request(bmia_pkg::ACT_FREE, FID_W'(ID_COUNT)); // first invalid identifier
        send_request(bmia_pkg::ACT_FREE, 11'h7FF);
        send_request(bmia_pkg::ACT_FREE, 11'h555);
        send_request(bmia_pkg::ACT_FREE, 11'h2AA);
        send_request(bmia_pkg::ACT_ALLOC, '0);
        send_request(bmia_pkg::ACT_FREE, 11'd0);
        send_request(bmia_pkg::ACT_FREE, 11'd2);
        repeat (3) send_request(bmia_pkg::ACT_ALLOC, '0);
        wait_drained();
    endtask

    task automatic test_result_backpressure();
        hold_request = 1'b1;
        send_mixed(16, 30);
        wait_drained();
    endtask

    task automatic test_random_mix();
        send_mixed(200, 40);
        wait_drained();
    endtask

    // Allocate until the map is full, then probe full and the last identifier
    task automatic test_fill_until_full();
        while (ids_in_use() < ID_COUNT) begin
            if ($urandom_range(0, 19) == 0)
                send_request(bmia_pkg::ACT_FREE, pick_free_target());
            else
                send_request(bmia_pkg::ACT_ALLOC, FID_W'($urandom_range(0, 2047)));
        end
        repeat (4) send_request(bmia_pkg::ACT_ALLOC, '0);
        send_request(bmia_pkg::ACT_FREE, FID_W'(ID_COUNT - 1));
        send_request(bmia_pkg::ACT_ALLOC, '0);
        send_request(bmia_pkg::ACT_ALLOC, '0);
        wait_drained();
    endtask

    task automatic test_churn_near_full();
        gaps_on = 1'b0;
        send_mixed(120, 45);
        wait_drained();
    endtask

    initial begin : main_sequence
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_result_backpressure();
        test_random_mix();
        test_fill_until_full();
        test_churn_near_full();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (owed_results.size() != 0) note_mismatch("results still owed at end");
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
